// File: rtl/core/xcfp_pkg.sv
// shared types and constants for the xor checked frame parser
// depends on nothing; imported by the controller, the datapath and the top level
package xcfp_pkg;

  // payload buffer geometry
  localparam int unsigned MAX_PAYLOAD = 16;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned IDX_W       = $clog2(MAX_PAYLOAD);
  localparam int unsigned LEN_W       = $clog2(MAX_PAYLOAD + 1);

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_HEADER = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FOOTER = CFG_IDX_W'(1);

  // configuration reset values
  localparam logic [BYTE_W-1:0] HEADER_RST = 8'hAA;
  localparam logic [BYTE_W-1:0] FOOTER_RST = 8'h55;

  // frame phases of the controller
  typedef enum logic [2:0] {
    ST_HEADER,
    ST_COMMAND,
    ST_ID,
    ST_LENGTH,
    ST_DATA,
    ST_CHECK,
    ST_FOOTER,
    ST_EMIT
  } ctrl_state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic ld_command;
    logic ld_id;
    logic ld_length;
    logic ld_data;
    logic ld_check;
    logic emit_clear;
    logic emit_step;
  } dp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic header_hit;
    logic length_over;
    logic length_byte_zero;
    logic data_done;
    logic footer_ok;
    logic read_last;
    logic out_free;
  } dp_sts_t;

endpackage

// File: rtl/core/xcfp_ctrl.sv
// frame phase state machine of the xor checked frame parser
// depends on xcfp_pkg; drives datapath commands from datapath status
module xcfp_ctrl import xcfp_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        accept;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_HEADER;
    end else begin
      state_q <= state_d;
    end
  end

  // input is held off only while the stored payload is read out
  assign in_stall_o = (state_q == ST_EMIT);
  assign accept     = in_valid_i && !in_stall_o;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_HEADER: begin
        if (accept && sts_i.header_hit) begin
          state_d = ST_COMMAND;
        end
      end
      ST_COMMAND: begin
        if (accept) begin
          cmd_o.ld_command = 1'b1;
          state_d          = ST_ID;
        end
      end
      ST_ID: begin
        if (accept) begin
          cmd_o.ld_id = 1'b1;
          state_d     = ST_LENGTH;
        end
      end
      ST_LENGTH: begin
        if (accept) begin
          if (sts_i.length_over) begin
            state_d = ST_HEADER;
          end else begin
            cmd_o.ld_length = 1'b1;
            state_d = sts_i.length_byte_zero ? ST_CHECK : ST_DATA;
          end
        end
      end
      ST_DATA: begin
        if (accept) begin
          cmd_o.ld_data = 1'b1;
          if (sts_i.data_done) begin
            state_d = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (accept) begin
          cmd_o.ld_check = 1'b1;
          state_d        = ST_FOOTER;
        end
      end
      ST_FOOTER: begin
        if (accept) begin
          cmd_o.emit_clear = 1'b1;
          state_d = sts_i.footer_ok ? ST_EMIT : ST_HEADER;
        end
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit_step = 1'b1;
          if (sts_i.read_last) begin
            state_d = ST_HEADER;
          end
        end
      end
      default: begin
        state_d = ST_HEADER;
      end
    endcase
  end

endmodule

// File: rtl/core/xcfp_dp.sv
// datapath of the xor checked frame parser: config, frame fields, payload
// buffer, running xor and result register; depends on xcfp_pkg
module xcfp_dp import xcfp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration writes
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [BYTE_W-1:0]    cfg_data_i,
  // received byte
  input  logic [BYTE_W-1:0]    rx_byte_i,
  // control
  input  dp_cmd_t              cmd_i,
  output dp_sts_t              sts_o,
  // result word
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [BYTE_W-1:0]    command_o,
  output logic [BYTE_W-1:0]    packet_id_o,
  output logic [LEN_W-1:0]     payload_length_o,
  output logic                 has_payload_o,
  output logic [IDX_W-1:0]     byte_index_o,
  output logic [BYTE_W-1:0]    payload_byte_o,
  output logic                 last_o
);

  logic [BYTE_W-1:0] header_q, footer_q;
  logic [BYTE_W-1:0] command_q, id_q, check_q, xor_q;
  logic [LEN_W-1:0]  length_q, count_q, count_inc;
  logic [IDX_W-1:0]  rd_q;
  logic [BYTE_W-1:0] payload_mem_q [MAX_PAYLOAD];
  logic              length_zero;

  // result register
  logic              out_valid_q;
  logic [BYTE_W-1:0] out_command_q, out_id_q, out_byte_q;
  logic [LEN_W-1:0]  out_length_q;
  logic              out_has_q, out_last_q;
  logic [IDX_W-1:0]  out_index_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q <= HEADER_RST;
      footer_q <= FOOTER_RST;
    end else if (cfg_we_i) begin
      if (cfg_index_i == REG_HEADER) begin
        header_q <= cfg_data_i;
      end else if (cfg_index_i == REG_FOOTER) begin
        footer_q <= cfg_data_i;
      end
    end
  end

  assign count_inc   = count_q + LEN_W'(1);
  assign length_zero = (length_q == '0);

  // frame fields, byte count and running xor
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      command_q <= '0;
      id_q      <= '0;
      length_q  <= '0;
      count_q   <= '0;
      check_q   <= '0;
      xor_q     <= '0;
      rd_q      <= '0;
    end else begin
      if (cmd_i.ld_command) begin
        command_q <= rx_byte_i;
        xor_q     <= rx_byte_i;
      end
      if (cmd_i.ld_id) begin
        id_q  <= rx_byte_i;
        xor_q <= xor_q ^ rx_byte_i;
      end
      if (cmd_i.ld_length) begin
        length_q <= LEN_W'(rx_byte_i);
        count_q  <= '0;
        xor_q    <= xor_q ^ rx_byte_i;
      end
      if (cmd_i.ld_data) begin
        count_q <= count_inc;
        xor_q   <= xor_q ^ rx_byte_i;
      end
      if (cmd_i.ld_check) begin
        check_q <= rx_byte_i;
      end
      if (cmd_i.emit_clear) begin
        rd_q <= '0;
      end else if (cmd_i.emit_step) begin
        rd_q <= rd_q + IDX_W'(1);
      end
    end
  end

  // payload buffer write
  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_data) begin
      payload_mem_q[count_q[IDX_W-1:0]] <= rx_byte_i;
    end
  end

  // result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_step) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result register payload, buffer read registered here
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_step) begin
      out_command_q <= command_q;
      out_id_q      <= id_q;
      out_length_q  <= length_q;
      out_has_q     <= !length_zero;
      out_index_q   <= rd_q;
      out_byte_q    <= length_zero ? '0 : payload_mem_q[rd_q];
      out_last_q    <= sts_o.read_last;
    end
  end

  // status to controller
  always_comb begin
    sts_o                  = '0;
    sts_o.header_hit       = (rx_byte_i == header_q);
    sts_o.length_over      = (rx_byte_i > BYTE_W'(MAX_PAYLOAD));
    sts_o.length_byte_zero = (rx_byte_i == '0);
    sts_o.data_done        = (count_inc >= length_q);
    sts_o.footer_ok        = (rx_byte_i == footer_q) && (xor_q == check_q);
    sts_o.read_last        = length_zero || ((LEN_W'(rd_q) + LEN_W'(1)) == length_q);
    sts_o.out_free         = !out_valid_q || !out_stall_i;
  end

  assign out_valid_o      = out_valid_q;
  assign command_o        = out_command_q;
  assign packet_id_o      = out_id_q;
  assign payload_length_o = out_length_q;
  assign has_payload_o    = out_has_q;
  assign byte_index_o     = out_index_q;
  assign payload_byte_o   = out_byte_q;
  assign last_o           = out_last_q;

endmodule

// File: rtl/core/xor_checked_frame_parser_top.sv
// xor checked frame parser: one received byte per input word; a good frame
// gives one result word per payload byte, or one word for an empty frame.
// the footer of a good frame starts a readout of max(length, 1) steps, with no
// step while a result waits on a stalled result side, one buffer entry per
// step, input stalled meanwhile. the first result is registered in the result
// register after the controller has entered its readout state.
// reset: hunting for header, header 0xAA, footer 0x55, no result pending.
module xor_checked_frame_parser_top import xcfp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration write channel
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [BYTE_W-1:0]    cfg_data_i,
  // input words
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [BYTE_W-1:0]    rx_byte_i,
  // result words
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [BYTE_W-1:0]    command_o,
  output logic [BYTE_W-1:0]    packet_id_o,
  output logic [LEN_W-1:0]     payload_length_o,
  output logic                 has_payload_o,
  output logic [IDX_W-1:0]     byte_index_o,
  output logic [BYTE_W-1:0]    payload_byte_o,
  output logic                 last_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // configuration is always taken
  assign cfg_ready_o = 1'b1;

  // frame state machine
  xcfp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath
  xcfp_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_valid_i && cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .rx_byte_i        (rx_byte_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .command_o        (command_o),
    .packet_id_o      (packet_id_o),
    .payload_length_o (payload_length_o),
    .has_payload_o    (has_payload_o),
    .byte_index_o     (byte_index_o),
    .payload_byte_o   (payload_byte_o),
    .last_o           (last_o)
  );

  // no byte is loaded while the buffer is read out
  a_no_load_in_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> !(cmd.ld_command || cmd.ld_id || cmd.ld_length ||
                     cmd.ld_data || cmd.ld_check))
    else $error("byte loaded during readout");

  // a readout step never overwrites a result still waiting
  a_step_only_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit_step |-> sts.out_free)
    else $error("result overwritten");

  // an empty frame result is a single last word with zero data
  a_empty_frame_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !has_payload_o) |->
      (last_o && byte_index_o == '0 && payload_byte_o == '0 && payload_length_o == '0))
    else $error("bad empty frame result");

  // at most one frame field load or readout step per cycle
  a_single_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.ld_command, cmd.ld_id, cmd.ld_length, cmd.ld_data, cmd.ld_check,
              cmd.emit_step}))
    else $error("conflicting datapath commands");

endmodule
